// ===== design/dad_pkg.sv =====
package dad_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int ADD_W   = 20;
	localparam int DNUM_W  = 23;  // day number from year 0, Jan 1
	localparam int REM_W   = 18;  // day within a 400-year era
	localparam int ERA_W   = 6;
	localparam int DOY_W   = 9;

	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd16383;
	localparam logic [17:0] ERA_DAYS  = 18'd146097;
	localparam logic [15:0] CENT_LONG = 16'd36525;
	localparam logic [15:0] CENT_DAYS = 16'd36524;
	localparam logic [10:0] QUAD_DAYS = 11'd1461;

	// reciprocals: exact floor over the value ranges used here
	localparam logic [10:0] RCP_25    = 11'd1311;        // >> 15
	localparam logic [22:0] RCP_ERA   = 23'd7525902;     // >> 40
	localparam logic [21:0] RCP_QUAD  = 22'd2939745;     // >> 32

	// days in the year before the first of month m
	function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DOY_W-1:0] c;
		unique case (m)
			4'd1:    c = 9'd0;
			4'd2:    c = 9'd31;
			4'd3:    c = 9'd59;
			4'd4:    c = 9'd90;
			4'd5:    c = 9'd120;
			4'd6:    c = 9'd151;
			4'd7:    c = 9'd181;
			4'd8:    c = 9'd212;
			4'd9:    c = 9'd243;
			4'd10:   c = 9'd273;
			4'd11:   c = 9'd304;
			4'd12:   c = 9'd334;
			default: c = 9'd0;
		endcase
		if (leap && m > 4'd2)
			c = c + 9'd1;
		return c;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] l;
		unique case (m)
			4'd2:                      l = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
			default:                   l = 5'd31;
		endcase
		return l;
	endfunction

endpackage

// ===== design/dad_to_days.sv =====
module dad_to_days import dad_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  logic [YEAR_W-1:0]   y,
	input  logic [MONTH_W-1:0]  m,
	input  logic [DAY_W-1:0]    d,
	input  logic [ADD_W-1:0]    add,
	output logic                out_v,
	output logic [DNUM_W-1:0]   dnum
);

	// stage 1: era of the start year, month clamp
	logic [20:0]        yq_prod;
	logic [MONTH_W-1:0] m_c;
	assign yq_prod = {11'd0, y[YEAR_W-1:4]} * {10'd0, RCP_25};
	always_comb begin
		m_c = m;
		if (m == 4'd0)
			m_c = 4'd1;
		else if (m > 4'd12)
			m_c = 4'd12;
	end

	logic               v_s1;
	logic [YEAR_W-1:0]  y_s1;
	logic [MONTH_W-1:0] m_s1;
	logic [DAY_W-1:0]   d_s1;
	logic [ADD_W-1:0]   add_s1;
	logic [ERA_W-1:0]   era_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			y_s1   <= y;
			m_s1   <= m_c;
			d_s1   <= d;
			add_s1 <= add;
			era_s1 <= yq_prod[20:15];
		end
	end

	// stage 2: year within era, leap, day clamp, day of year, era base
	logic [YEAR_W-1:0]  era_y;
	logic [8:0]         r400;
	logic               leap;
	logic [DAY_W-1:0]   mlen;
	logic [DAY_W-1:0]   d_c;
	logic [DOY_W-1:0]   doy;
	logic [DNUM_W-1:0]  eday;

	assign era_y = YEAR_W'({8'd0, era_s1} * 14'd400);
	assign r400  = 9'(y_s1 - era_y);
	assign leap  = (y_s1[1:0] == 2'b00) &&
		!(r400 == 9'd100 || r400 == 9'd200 || r400 == 9'd300);
	assign mlen  = month_len(m_s1, leap);
	always_comb begin
		d_c = d_s1;
		if (d_s1 == 5'd0)
			d_c = 5'd1;
		else if (d_s1 > mlen)
			d_c = mlen;
	end
	assign doy  = cum_days(m_s1, leap) + {4'd0, d_c} - 9'd1;
	assign eday = DNUM_W'({17'd0, era_s1} * {5'd0, ERA_DAYS});

	logic               v_s2;
	logic [8:0]         r_s2;
	logic [DOY_W-1:0]   doy_s2;
	logic [ADD_W-1:0]   add_s2;
	logic [DNUM_W-1:0]  eday_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r_s2    <= r400;
			doy_s2  <= doy;
			add_s2  <= add_s1;
			eday_s2 <= eday;
		end
	end

	// stage 3: days before the year inside the era, then the total
	logic [2:0]         cent_up;
	logic [6:0]         lcount;
	logic [17:0]        dby;
	logic [DNUM_W-1:0]  total;

	always_comb begin
		if (r_s2 == 9'd0)
			cent_up = 3'd0;
		else if (r_s2 <= 9'd100)
			cent_up = 3'd1;
		else if (r_s2 <= 9'd200)
			cent_up = 3'd2;
		else if (r_s2 <= 9'd300)
			cent_up = 3'd3;
		else
			cent_up = 3'd4;
	end
	// leap years in [era start, year): era start itself is leap
	assign lcount = 7'((r_s2 + 9'd3) >> 2) - {4'd0, cent_up} + {6'd0, (r_s2 != 9'd0)};
	assign dby    = 18'({9'd0, r_s2} * 18'd365) + {11'd0, lcount};
	assign total  = eday_s2 + {5'd0, dby} + {14'd0, doy_s2} + {3'd0, add_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v <= 1'b0;
		else if (en)
			out_v <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en)
			dnum <= total;
	end

endmodule

// ===== design/dad_from_days.sv =====
module dad_from_days import dad_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  logic [DNUM_W-1:0]   dnum,
	output logic                out_v,
	output logic [YEAR_W-1:0]   year,
	output logic [MONTH_W-1:0]  month,
	output logic [DAY_W-1:0]    day,
	output logic                ovf
);

	// stage 4: era number
	logic [45:0] era_prod;
	assign era_prod = {23'd0, dnum} * {23'd0, RCP_ERA};

	logic              v_s4;
	logic [DNUM_W-1:0] d_s4;
	logic [ERA_W-1:0]  era_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= in_v;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_s4   <= dnum;
			era_s4 <= era_prod[45:40];
		end
	end

	// stage 5: day within era
	logic [DNUM_W-1:0] era_base;
	assign era_base = DNUM_W'({17'd0, era_s4} * {5'd0, ERA_DAYS});

	logic              v_s5;
	logic [REM_W-1:0]  rem_s5;
	logic [ERA_W-1:0]  era_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s5 <= REM_W'(d_s4 - era_base);
			era_s5 <= era_s4;
		end
	end

	// stage 6: century; later centuries shifted one day so 4-year blocks line up
	logic [1:0]       cent;
	logic [REM_W-1:0] t;
	logic [15:0]      rc;

	assign t = rem_s5 - 18'd1;
	always_comb begin
		if (rem_s5 < {2'd0, CENT_LONG}) begin
			cent = 2'd0;
			rc   = rem_s5[15:0];
		end else begin
			if (t < 18'd73048)
				cent = 2'd1;
			else if (t < 18'd109572)
				cent = 2'd2;
			else
				cent = 2'd3;
			rc = 16'(t - 18'({16'd0, cent} * {2'd0, CENT_DAYS})) + 16'd1;
		end
	end

	logic             v_s6;
	logic [1:0]       c_s6;
	logic [15:0]      rc_s6;
	logic [ERA_W-1:0] era_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s6   <= cent;
			rc_s6  <= rc;
			era_s6 <= era_s5;
		end
	end

	// stage 7: 4-year block
	logic [37:0] quad_prod;
	assign quad_prod = {22'd0, rc_s6} * {16'd0, RCP_QUAD};

	logic             v_s7;
	logic [4:0]       q4_s7;
	logic [1:0]       c_s7;
	logic [15:0]      rc_s7;
	logic [ERA_W-1:0] era_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			q4_s7  <= quad_prod[36:32];
			c_s7   <= c_s6;
			rc_s7  <= rc_s6;
			era_s7 <= era_s6;
		end
	end

	// stage 8: year within block and day of year
	logic [10:0]      r4;
	logic [10:0]      r4m;
	logic             short0;
	logic [1:0]       yb;
	logic [DOY_W-1:0] doy;
	logic             leap;

	assign r4     = 11'(rc_s7 - 16'({11'd0, q4_s7} * {5'd0, QUAD_DAYS}));
	assign r4m    = r4 - 11'd1;
	assign short0 = (c_s7 != 2'd0) && (q4_s7 == 5'd0);
	always_comb begin
		if (r4 < 11'd366) begin
			yb   = 2'd0;
			doy  = short0 ? r4m[8:0] : r4[8:0];
			leap = !short0;
		end else begin
			if (r4m < 11'd730)
				yb = 2'd1;
			else if (r4m < 11'd1095)
				yb = 2'd2;
			else
				yb = 2'd3;
			doy  = 9'(r4m - 11'({9'd0, yb} * 11'd365));
			leap = 1'b0;
		end
	end

	logic             v_s8;
	logic [1:0]       yb_s8;
	logic [DOY_W-1:0] doy_s8;
	logic             leap_s8;
	logic [4:0]       q4_s8;
	logic [1:0]       c_s8;
	logic [ERA_W-1:0] era_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			yb_s8   <= yb;
			doy_s8  <= doy;
			leap_s8 <= leap;
			q4_s8   <= q4_s7;
			c_s8    <= c_s7;
			era_s8  <= era_s7;
		end
	end

	// stage 9: assemble year, month and day
	logic [14:0]        yfull;
	logic [MONTH_W-1:0] mon;
	logic [DAY_W-1:0]   dom;

	assign yfull = 15'({9'd0, era_s8} * 15'd400) + 15'({13'd0, c_s8} * 15'd100)
		+ {8'd0, q4_s8, 2'b00} + {13'd0, yb_s8};
	always_comb begin
		mon = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (doy_s8 >= cum_days(MONTH_W'(k), leap_s8))
				mon = MONTH_W'(k);
		end
	end
	assign dom = DAY_W'(doy_s8 - cum_days(mon, leap_s8) + 9'd1);

	logic              v_s9;
	logic [YEAR_W-1:0] year_s9;
	logic [MONTH_W-1:0] mon_s9;
	logic [DAY_W-1:0]  day_s9;
	logic              ovf_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (en)
			v_s9 <= v_s8;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s9  <= yfull > {1'b0, YEAR_MAX};
			year_s9 <= (yfull > {1'b0, YEAR_MAX}) ? YEAR_MAX : yfull[YEAR_W-1:0];
			mon_s9  <= mon;
			day_s9  <= dom;
		end
	end

	assign out_v = v_s9;
	assign year  = year_s9;
	assign month = mon_s9;
	assign day   = day_s9;
	assign ovf   = ovf_s9;

endmodule

// ===== design/date_add_days.sv =====
// Gregorian date plus a day count.
// Input channel (in_valid/in_ready): start_year, start_month, start_day,
// add_days. A start month out of 1..12 is clamped to that range, a start
// day of 0 is taken as 1 and a day past the month end as the last day.
// Output channel (out_valid/out_ready): end_year, end_month, end_day,
// year_overflow. When the result year passes 16383, end_year holds 16383,
// year_overflow is set, and month and day are those of the true date.
// The date goes to a day number from year 0, the count is added, and the
// number is turned back into a date through 400-year, century, 4-year and
// year steps. Nine pipeline stages; one word per cycle is taken in steady
// flow, while the receiver does not stall.
// A stalled receiver freezes the whole pipeline; in_ready follows
// out_ready while the output register is full, so no word is dropped.
// Reset clears all valid bits; the pipeline comes up empty and ready.
module date_add_days import dad_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [YEAR_W-1:0]   start_year,
	input  logic [MONTH_W-1:0]  start_month,
	input  logic [DAY_W-1:0]    start_day,
	input  logic [ADD_W-1:0]    add_days,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [YEAR_W-1:0]   end_year,
	output logic [MONTH_W-1:0]  end_month,
	output logic [DAY_W-1:0]    end_day,
	output logic                year_overflow
);

	logic              en;
	logic              dn_v;
	logic [DNUM_W-1:0] dn;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	dad_to_days u_to_days (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (in_valid),
		.y      (start_year),
		.m      (start_month),
		.d      (start_day),
		.add    (add_days),
		.out_v  (dn_v),
		.dnum   (dn)
	);

	dad_from_days u_from_days (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (dn_v),
		.dnum   (dn),
		.out_v  (out_valid),
		.year   (end_year),
		.month  (end_month),
		.day    (end_day),
		.ovf    (year_overflow)
	);

endmodule

// ===== test/date_add_days_tb.sv =====
`timescale 1ns / 100ps

module date_add_days_tb;
	import dad_pkg::*;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic               ovf;
	} date_t;

	localparam int LIMIT_CYCLES = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [YEAR_W-1:0]  start_year = '0;
	logic [MONTH_W-1:0] start_month = '0;
	logic [DAY_W-1:0]   start_day = '0;
	logic [ADD_W-1:0]   add_days = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [YEAR_W-1:0]  end_year;
	logic [MONTH_W-1:0] end_month;
	logic [DAY_W-1:0]   end_day;
	logic               year_overflow;

	date_t expected_dates[$];
	int errors = 0;
	int cycles = 0;
	bit rx_idle_en = 1'b1;
	bit tx_idle_en = 1'b1;
	int hold_off = 0;
	int rx_gap = 0;

	date_add_days dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic bit leap_year(int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned days_of_month(int unsigned m, int unsigned y);
		case (m)
			2: return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic date_t date_after(int unsigned y, int unsigned m, int unsigned d,
		int unsigned left);
		int unsigned rest, dd, len;
		date_t r;
		if (m < 1) m = 1;
		if (m > 12) m = 12;
		if (d < 1) d = 1;
		len = days_of_month(m, y);
		if (d > len) d = len;
		rest = 0;
		dd = d;
		for (int unsigned k = m; k <= 12; k++) begin
			rest += days_of_month(k, y) - dd + 1;
			dd = 1;
		end
		if (left >= rest) begin
			left -= rest;
			y++;
			m = 1;
			d = 1;
		end
		forever begin
			len = leap_year(y) ? 366 : 365;
			if (left >= len - d + 1) begin
				left -= len - d + 1;
				y++;
				d = 1;
			end else break;
		end
		forever begin
			len = days_of_month(m, y);
			if (m < 12 && left >= len - d + 1) begin
				left -= len - d + 1;
				m++;
				d = 1;
			end else break;
		end
		d += left;
		r.ovf = y > YEAR_MAX;
		r.year = r.ovf ? YEAR_MAX : y[YEAR_W-1:0];
		r.month = m[MONTH_W-1:0];
		r.day = d[DAY_W-1:0];
		return r;
	endfunction

	// one word into the block; the expectation is queued on acceptance
	// valid stays up after acceptance so back-to-back words need one assignment
	task automatic send_date(int unsigned y, int unsigned m, int unsigned d, int unsigned n);
		int gap;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_year <= YEAR_W'(y);
		start_month <= MONTH_W'(m);
		start_day <= DAY_W'(d);
		add_days <= ADD_W'(n);
		do @(posedge clk); while (!in_ready);
		expected_dates.push_back(date_after(y, m, d, n));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_dates.size() != 0) @(posedge clk);
	endtask

	// receiver: random stall bursts, plus a long hold-off when asked
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			out_ready <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
			rx_gap <= $urandom_range(0, 17);
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		date_t exp_d;
		if (arst_n && out_valid && out_ready) begin
			if (expected_dates.size() == 0) begin
				$display("%0t: unexpected word %0d-%0d-%0d ovf %0b", $time,
					end_year, end_month, end_day, year_overflow);
				errors++;
			end else begin
				exp_d = expected_dates.pop_front();
				if (exp_d.year !== end_year || exp_d.month !== end_month ||
					exp_d.day !== end_day || exp_d.ovf !== year_overflow) begin
					$display("%0t: expected %0d-%0d-%0d ovf %0b, got %0d-%0d-%0d ovf %0b",
						$time, exp_d.year, exp_d.month, exp_d.day, exp_d.ovf,
						end_year, end_month, end_day, year_overflow);
					errors++;
				end
			end
		end
	end

	// field extremes and every clamping case
	task automatic test_directed();
		send_date(1, 1, 1, 0);
		send_date(16383, 12, 31, 0);
		send_date(16383, 12, 31, 1);
		send_date(16383, 1, 1, 1048575);
		send_date(1, 1, 1, 1048575);
		send_date(2000, 2, 28, 1);
		send_date(1900, 2, 28, 1);
		send_date(2024, 2, 29, 366);
		send_date(2023, 12, 31, 1);
		send_date(2023, 0, 0, 10);
		send_date(2023, 13, 5, 3);
		send_date(2023, 15, 31, 0);
		send_date(2023, 4, 31, 0);
		send_date(2023, 2, 31, 1);
		send_date(0, 1, 1, 0);
		send_date(0, 2, 29, 5);
		send_date(0, 15, 31, 1048575);
		send_date(16383, 15, 0, 1048575);
		send_date(9999, 6, 15, 524288);
		send_date(2100, 3, 1, 365);
		drain();
	endtask

	task automatic send_random(int count);
		int unsigned y, n;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0: y = $urandom_range(0, 16383);
				1: y = $urandom_range(1, 2500);
				2: y = 16383 - $urandom_range(0, 3000);
				default: y = 400 * $urandom_range(0, 40) + $urandom_range(0, 4) * 25;
			endcase
			case ($urandom_range(0, 2))
				0: n = $urandom_range(0, 1048575);
				1: n = $urandom_range(0, 800);
				default: n = $urandom_range(0, 40000);
			endcase
			if ($urandom_range(0, 9) == 0)
				send_date(y, $urandom_range(0, 15), $urandom_range(0, 31), n);
			else
				send_date(y, $urandom_range(1, 12), $urandom_range(1, 28), n);
		end
	endtask

	task automatic test_random();
		send_random(1400);
		drain();
	endtask

	// receiver holds off long enough for the pipeline to fill and stall input
	task automatic test_backpressure();
		@(posedge clk);
		hold_off <= 60;
		send_random(40);
		drain();
	endtask

	// final stretch at full rate
	task automatic test_streaming();
		rx_idle_en = 1'b0;
		tx_idle_en = 1'b0;
		send_random(390);
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		test_streaming();
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== date_add_days.f =====
design/dad_pkg.sv
design/dad_to_days.sv
design/dad_from_days.sv
design/date_add_days.sv
test/date_add_days_tb.sv
